FILE: sv/joint_speed_pid_controller_top_defines.svh
// assertion helpers shared by the controller top level
`ifndef JOINT_SPEED_PID_CONTROLLER_TOP_DEFINES_SVH
`define JOINT_SPEED_PID_CONTROLLER_TOP_DEFINES_SVH

// same-cycle implication, checked on every rising edge outside reset
`define JSPC_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("jspc implication check failed");

// next-cycle implication
`define JSPC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("jspc next-cycle check failed");

`endif

FILE: sv/jspc_pkg.sv
package jspc_pkg;

   localparam int DataWidth     = 16;
   localparam int LimWidth      = 15;
   localparam int CsrIndexWidth = 3;
   localparam int ProdWidth     = 2 * DataWidth;
   localparam int AccWidth      = ProdWidth + 2;
   localparam int PidDivisor    = 32;
   localparam int PidShift      = $clog2(PidDivisor);

   typedef enum logic [1:0] {
      MODE_OFF    = 2'd0,
      MODE_DIRECT = 2'd1,
      MODE_PID    = 2'd2,
      MODE_HOLD   = 2'd3
   } mode_type;

   typedef enum logic [CsrIndexWidth-1:0] {
      REG_SPEED_CAP      = 3'd0,
      REG_SLOPE_LIMIT    = 3'd1,
      REG_INTEGRAL_LIMIT = 3'd2,
      REG_GAIN_P         = 3'd3,
      REG_GAIN_I         = 3'd4,
      REG_GAIN_D         = 3'd5,
      REG_PWM_LIMIT      = 3'd6,
      REG_PWM_DEADBAND   = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [LimWidth-1:0]         speed_cap;
      logic [LimWidth-1:0]         slope_limit;
      logic [LimWidth-1:0]         integral_limit;
      logic signed [DataWidth-1:0] gain_p;
      logic signed [DataWidth-1:0] gain_i;
      logic signed [DataWidth-1:0] gain_d;
      logic [LimWidth-1:0]         pwm_limit;
      logic [LimWidth-1:0]         pwm_deadband;
   } cfg_type;

   // fields carried along the pipeline to the result
   typedef struct packed {
      logic signed [DataWidth-1:0] speed;
      logic [DataWidth-1:0]        position;
      mode_type                    mode;
      logic signed [DataWidth-1:0] command;
      logic signed [DataWidth-1:0] target;
      logic signed [DataWidth-1:0] ramp;
   } tick_type;

   typedef struct packed {
      tick_type                    tick;
      logic signed [DataWidth-1:0] error;
      logic signed [DataWidth-1:0] error_sum;
      logic signed [DataWidth-1:0] error_delta;
   } front_type;

   typedef struct packed {
      tick_type                    tick;
      logic signed [ProdWidth-1:0] prod_p;
      logic signed [ProdWidth-1:0] prod_i;
      logic signed [ProdWidth-1:0] prod_d;
   } gain_type;

   function automatic logic signed [DataWidth-1:0] limit_sym(
      input logic signed [DataWidth-1:0] value,
      input logic [LimWidth-1:0]         limit
   );
      logic signed [DataWidth:0] wide;
      logic signed [DataWidth:0] high;
      logic signed [DataWidth:0] low;
      wide = {value[DataWidth-1], value};
      high = $signed({2'b00, limit});
      low  = -high;
      if (wide > high) begin
         limit_sym = high[DataWidth-1:0];
      end else if (wide < low) begin
         limit_sym = low[DataWidth-1:0];
      end else begin
         limit_sym = value;
      end
   endfunction

   // true when the magnitude lies strictly inside the band
   function automatic logic in_deadband(
      input logic signed [DataWidth-1:0] value,
      input logic [LimWidth-1:0]         band
   );
      logic signed [DataWidth:0] wide;
      logic signed [DataWidth:0] high;
      wide = {value[DataWidth-1], value};
      high = $signed({2'b00, band});
      in_deadband = (wide < high) && (wide > -high);
   endfunction

   // divide by the pid divisor rounding toward zero, keep the low 16 bits
   function automatic logic signed [DataWidth-1:0] scale_down(
      input logic signed [AccWidth-1:0] acc
   );
      logic [AccWidth-1:0] biased;
      biased = acc + (acc[AccWidth-1] ? AccWidth'(PidDivisor - 1) : AccWidth'(0));
      scale_down = biased[PidShift +: DataWidth];
   endfunction

endpackage

FILE: sv/jspc_front.sv
module jspc_front (
   input  logic                                    clock,
   input  logic                                    reset,
   input  jspc_pkg::cfg_type                       cfg,
   input  logic                                    in_valid,
   output logic                                    in_ready,
   input  logic [jspc_pkg::DataWidth-1:0]          in_encoder_count,
   input  logic [1:0]                              in_mode,
   input  logic signed [jspc_pkg::DataWidth-1:0]   in_speed_command,
   output logic                                    out_valid,
   input  logic                                    out_ready,
   output jspc_pkg::front_type                     out_data
);

   logic                                   capt_valid_ff;
   logic [jspc_pkg::DataWidth-1:0]         capt_enc_ff;
   jspc_pkg::mode_type                     capt_mode_ff;
   logic signed [jspc_pkg::DataWidth-1:0]  capt_cmd_ff;

   logic                                   front_valid_ff, front_valid_in;
   jspc_pkg::front_type                    front_ff, front_in;

   logic [jspc_pkg::DataWidth-1:0]         last_pos_ff, last_pos_in;
   logic signed [jspc_pkg::DataWidth-1:0]  error_sum_ff, error_sum_in;
   logic signed [jspc_pkg::DataWidth-1:0]  last_error_ff, last_error_in;
   logic signed [jspc_pkg::DataWidth-1:0]  held_target_ff, held_target_in;

   logic                                   advance;
   logic signed [jspc_pkg::DataWidth-1:0]  speed;
   logic signed [jspc_pkg::DataWidth-1:0]  clamped_target;
   logic signed [jspc_pkg::DataWidth-1:0]  speed_gap;
   logic signed [jspc_pkg::DataWidth-1:0]  error;
   logic signed [jspc_pkg::DataWidth-1:0]  raw_sum;
   logic signed [jspc_pkg::DataWidth-1:0]  pid_sum;

   assign advance   = !front_valid_ff || out_ready;
   assign in_ready  = !capt_valid_ff || advance;
   assign out_valid = front_valid_ff;
   assign out_data  = front_ff;

   always_comb begin
      speed          = capt_enc_ff - last_pos_ff;
      clamped_target = jspc_pkg::limit_sym(capt_cmd_ff, cfg.speed_cap);
      speed_gap      = clamped_target - speed;
      error          = jspc_pkg::limit_sym(speed_gap, cfg.slope_limit);
      raw_sum        = error_sum_ff + error;
      pid_sum        = jspc_pkg::limit_sym(raw_sum, cfg.integral_limit);

      last_pos_in    = last_pos_ff;
      error_sum_in   = error_sum_ff;
      last_error_in  = last_error_ff;
      held_target_in = held_target_ff;
      front_valid_in = front_valid_ff;
      front_in       = front_ff;

      if (advance) begin
         front_valid_in = capt_valid_ff;
      end

      if (advance && capt_valid_ff) begin
         last_pos_in = capt_enc_ff;
         case (capt_mode_ff)
            jspc_pkg::MODE_OFF: begin
               error_sum_in = '0;
            end
            jspc_pkg::MODE_PID: begin
               error_sum_in   = pid_sum;
               last_error_in  = error;
               held_target_in = clamped_target;
            end
            default: begin
            end
         endcase

         front_in.tick.speed    = speed;
         front_in.tick.position = capt_enc_ff;
         front_in.tick.mode     = capt_mode_ff;
         front_in.tick.command  = capt_cmd_ff;
         front_in.tick.target   = (capt_mode_ff == jspc_pkg::MODE_PID) ?
                                  clamped_target : held_target_ff;
         front_in.tick.ramp     = speed + error;
         front_in.error         = error;
         front_in.error_sum     = pid_sum;
         front_in.error_delta   = error - last_error_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capt_valid_ff  <= 1'b0;
         front_valid_ff <= 1'b0;
         last_pos_ff    <= '0;
         error_sum_ff   <= '0;
         last_error_ff  <= '0;
         held_target_ff <= '0;
      end else begin
         if (in_ready) begin
            capt_valid_ff <= in_valid;
         end
         front_valid_ff <= front_valid_in;
         last_pos_ff    <= last_pos_in;
         error_sum_ff   <= error_sum_in;
         last_error_ff  <= last_error_in;
         held_target_ff <= held_target_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         capt_enc_ff  <= in_encoder_count;
         capt_mode_ff <= jspc_pkg::mode_type'(in_mode);
         capt_cmd_ff  <= in_speed_command;
      end
      front_ff <= front_in;
   end

endmodule

FILE: sv/jspc_gain.sv
module jspc_gain (
   input  logic                clock,
   input  logic                reset,
   input  jspc_pkg::cfg_type   cfg,
   input  logic                in_valid,
   output logic                in_ready,
   input  jspc_pkg::front_type in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output jspc_pkg::gain_type  out_data
);

   logic               gain_valid_ff;
   jspc_pkg::gain_type gain_ff, gain_in;

   assign in_ready  = !gain_valid_ff || out_ready;
   assign out_valid = gain_valid_ff;
   assign out_data  = gain_ff;

   always_comb begin
      gain_in.tick   = in_data.tick;
      gain_in.prod_p = jspc_pkg::ProdWidth'(cfg.gain_p)
                       * jspc_pkg::ProdWidth'(in_data.error);
      gain_in.prod_i = jspc_pkg::ProdWidth'(cfg.gain_i)
                       * jspc_pkg::ProdWidth'(in_data.error_sum);
      gain_in.prod_d = jspc_pkg::ProdWidth'(cfg.gain_d)
                       * jspc_pkg::ProdWidth'(in_data.error_delta);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_valid_ff <= 1'b0;
      end else if (in_ready) begin
         gain_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         gain_ff <= gain_in;
      end
   end

endmodule

FILE: sv/jspc_drive.sv
module jspc_drive (
   input  logic                                  clock,
   input  logic                                  reset,
   input  jspc_pkg::cfg_type                     cfg,
   input  logic                                  in_valid,
   output logic                                  in_ready,
   input  jspc_pkg::gain_type                    in_data,
   output logic                                  out_valid,
   input  logic                                  out_ready,
   output logic signed [jspc_pkg::DataWidth-1:0] out_measured_speed,
   output logic [jspc_pkg::DataWidth-1:0]        out_position,
   output logic [1:0]                            out_mode_echo,
   output logic signed [jspc_pkg::DataWidth-1:0] out_reported_pwm,
   output logic signed [jspc_pkg::DataWidth-1:0] out_target_speed,
   output logic signed [jspc_pkg::DataWidth-1:0] out_drive_output
);

   logic                                  scale_valid_ff;
   jspc_pkg::tick_type                    scale_tick_ff;
   logic signed [jspc_pkg::DataWidth-1:0] scale_pid_ff, scale_pid_in;
   logic                                  scale_ready;

   logic                                  rsp_valid_ff;
   logic                                  rsp_load;
   logic signed [jspc_pkg::DataWidth-1:0] drive_ff, drive_in;
   logic signed [jspc_pkg::DataWidth-1:0] speed_ff;
   logic [jspc_pkg::DataWidth-1:0]        position_ff;
   jspc_pkg::mode_type                    mode_ff;
   logic signed [jspc_pkg::DataWidth-1:0] reported_ff;
   logic signed [jspc_pkg::DataWidth-1:0] target_ff;

   logic signed [jspc_pkg::AccWidth-1:0]  acc;
   logic signed [jspc_pkg::DataWidth-1:0] drive_sum;
   logic signed [jspc_pkg::DataWidth-1:0] drive_clamped;
   logic signed [jspc_pkg::DataWidth-1:0] pid_drive;

   assign rsp_load    = !rsp_valid_ff || out_ready;
   assign scale_ready = !scale_valid_ff || rsp_load;
   assign in_ready    = scale_ready;

   always_comb begin
      acc = jspc_pkg::AccWidth'(in_data.prod_p) + jspc_pkg::AccWidth'(in_data.prod_i)
            + jspc_pkg::AccWidth'(in_data.prod_d);
      scale_pid_in = jspc_pkg::scale_down(acc);
   end

   always_comb begin
      drive_sum     = scale_tick_ff.ramp + scale_pid_ff;
      drive_clamped = jspc_pkg::limit_sym(drive_sum, cfg.pwm_limit);
      pid_drive     = jspc_pkg::in_deadband(drive_clamped, cfg.pwm_deadband) ?
                      '0 : drive_clamped;
      case (scale_tick_ff.mode)
         jspc_pkg::MODE_OFF:    drive_in = '0;
         jspc_pkg::MODE_DIRECT: drive_in = scale_tick_ff.command;
         jspc_pkg::MODE_PID:    drive_in = pid_drive;
         default:               drive_in = drive_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         drive_ff       <= '0;
      end else begin
         if (scale_ready) begin
            scale_valid_ff <= in_valid;
         end
         if (rsp_load) begin
            rsp_valid_ff <= scale_valid_ff;
         end
         // drive only moves when a beat lands in the result register
         if (rsp_load && scale_valid_ff) begin
            drive_ff <= drive_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (scale_ready && in_valid) begin
         scale_tick_ff <= in_data.tick;
         scale_pid_ff  <= scale_pid_in;
      end
      if (rsp_load && scale_valid_ff) begin
         speed_ff    <= scale_tick_ff.speed;
         position_ff <= scale_tick_ff.position;
         mode_ff     <= scale_tick_ff.mode;
         reported_ff <= drive_ff;
         target_ff   <= scale_tick_ff.target;
      end
   end

   assign out_valid          = rsp_valid_ff;
   assign out_measured_speed = speed_ff;
   assign out_position       = position_ff;
   assign out_mode_echo      = mode_ff;
   assign out_reported_pwm   = reported_ff;
   assign out_target_speed   = target_ff;
   assign out_drive_output   = drive_ff;

endmodule

FILE: sv/joint_speed_pid_controller_top.sv
// Speed controller for one joint: each request beat is one control tick carrying an encoder
// reading, a mode and a speed command, and produces exactly one response beat. The block takes
// one beat per clock cycle when the response side is not stalled, and raises rsp_valid with the
// result once the beat has passed the five register stages, from which the rate comes (input
// capture, the position and integral update, the gain multipliers, the divide-by-32 scaling,
// the drive clamp/deadband with the drive register), each handing on one beat per cycle.
// Stalls on rsp_ready only back up as far as the first empty stage. Registers are written
// through the csr_ port and should only be changed while no beat is in flight.
`include "joint_speed_pid_controller_top_defines.svh"

module joint_speed_pid_controller_top (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [jspc_pkg::DataWidth-1:0]        req_encoder_count,
   input  logic [1:0]                            req_mode,
   input  logic signed [jspc_pkg::DataWidth-1:0] req_speed_command,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [jspc_pkg::DataWidth-1:0] rsp_measured_speed,
   output logic [jspc_pkg::DataWidth-1:0]        rsp_position,
   output logic [1:0]                            rsp_mode_echo,
   output logic signed [jspc_pkg::DataWidth-1:0] rsp_reported_pwm,
   output logic signed [jspc_pkg::DataWidth-1:0] rsp_target_speed,
   output logic signed [jspc_pkg::DataWidth-1:0] rsp_drive_output,
   input  logic                                  csr_write_enable,
   input  logic [jspc_pkg::CsrIndexWidth-1:0]    csr_index,
   input  logic [jspc_pkg::DataWidth-1:0]        csr_write_data
);

   jspc_pkg::cfg_type   cfg_ff, cfg_in;

   logic                front_valid, front_ready;
   jspc_pkg::front_type front_data;
   logic                gain_valid, gain_ready;
   jspc_pkg::gain_type  gain_data;

   logic signed [jspc_pkg::DataWidth-1:0] pwm_high;
   logic                                  rsp_is_off;
   logic                                  rsp_is_hold;
   logic                                  rsp_is_pid;
   logic                                  rsp_in_limit;
   logic                                  rsp_take;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (jspc_pkg::csr_index_type'(csr_index))
            jspc_pkg::REG_SPEED_CAP:
               cfg_in.speed_cap = csr_write_data[jspc_pkg::LimWidth-1:0];
            jspc_pkg::REG_SLOPE_LIMIT:
               cfg_in.slope_limit = csr_write_data[jspc_pkg::LimWidth-1:0];
            jspc_pkg::REG_INTEGRAL_LIMIT:
               cfg_in.integral_limit = csr_write_data[jspc_pkg::LimWidth-1:0];
            jspc_pkg::REG_GAIN_P:       cfg_in.gain_p = csr_write_data;
            jspc_pkg::REG_GAIN_I:       cfg_in.gain_i = csr_write_data;
            jspc_pkg::REG_GAIN_D:       cfg_in.gain_d = csr_write_data;
            jspc_pkg::REG_PWM_LIMIT:
               cfg_in.pwm_limit = csr_write_data[jspc_pkg::LimWidth-1:0];
            jspc_pkg::REG_PWM_DEADBAND:
               cfg_in.pwm_deadband = csr_write_data[jspc_pkg::LimWidth-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   jspc_front u_front (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .in_valid         (req_valid),
      .in_ready         (req_ready),
      .in_encoder_count (req_encoder_count),
      .in_mode          (req_mode),
      .in_speed_command (req_speed_command),
      .out_valid        (front_valid),
      .out_ready        (front_ready),
      .out_data         (front_data)
   );

   jspc_gain u_gain (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_data   (front_data),
      .out_valid (gain_valid),
      .out_ready (gain_ready),
      .out_data  (gain_data)
   );

   jspc_drive u_drive (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg_ff),
      .in_valid           (gain_valid),
      .in_ready           (gain_ready),
      .in_data            (gain_data),
      .out_valid          (rsp_valid),
      .out_ready          (rsp_ready),
      .out_measured_speed (rsp_measured_speed),
      .out_position       (rsp_position),
      .out_mode_echo      (rsp_mode_echo),
      .out_reported_pwm   (rsp_reported_pwm),
      .out_target_speed   (rsp_target_speed),
      .out_drive_output   (rsp_drive_output)
   );

   assign pwm_high     = $signed({1'b0, cfg_ff.pwm_limit});
   assign rsp_is_off   = rsp_valid && (rsp_mode_echo == jspc_pkg::MODE_OFF);
   assign rsp_is_hold  = rsp_valid && (rsp_mode_echo == jspc_pkg::MODE_HOLD);
   assign rsp_is_pid   = rsp_valid && (rsp_mode_echo == jspc_pkg::MODE_PID);
   assign rsp_in_limit = (rsp_drive_output <= pwm_high) && (rsp_drive_output >= -pwm_high);
   assign rsp_take     = rsp_valid && rsp_ready;

   `JSPC_ASSERT_IMPLY(a_off_zero, rsp_is_off, rsp_drive_output == '0)
   `JSPC_ASSERT_IMPLY(a_hold_keeps, rsp_is_hold, rsp_drive_output == rsp_reported_pwm)
   `JSPC_ASSERT_IMPLY(a_pid_in_limit, rsp_is_pid, rsp_in_limit)
   `JSPC_ASSERT_IMPLY(a_empty_ready, !rsp_valid, req_ready)
   `JSPC_ASSERT_NEXT(a_chain, rsp_take, !rsp_valid || rsp_reported_pwm == $past(rsp_drive_output))

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

   localparam int SettingPhases = 7;
   localparam int TicksPerPhase = 236;
   localparam int CycleLimit    = 200000;
   localparam int ShownMismatches = 100;

   typedef struct packed {
      logic signed [jspc_pkg::DataWidth-1:0] speed;
      logic [jspc_pkg::DataWidth-1:0]        position;
      logic [1:0]                            mode;
      logic signed [jspc_pkg::DataWidth-1:0] pwm_before;
      logic signed [jspc_pkg::DataWidth-1:0] target;
      logic signed [jspc_pkg::DataWidth-1:0] drive;
   } tick_report_type;

   typedef struct packed {
      logic [jspc_pkg::DataWidth-1:0] enc;
      jspc_pkg::mode_type             mode;
      logic [jspc_pkg::DataWidth-1:0] cmd;
      logic                           typed;
      logic [jspc_pkg::DataWidth-1:0] speed;
      logic [jspc_pkg::DataWidth-1:0] pwm_before;
      logic [jspc_pkg::DataWidth-1:0] target;
      logic [jspc_pkg::DataWidth-1:0] drive;
   } directed_tick_type;

   logic                                  clock;
   logic                                  reset;
   logic                                  req_valid;
   logic                                  req_ready;
   logic [jspc_pkg::DataWidth-1:0]        req_encoder_count;
   logic [1:0]                            req_mode;
   logic signed [jspc_pkg::DataWidth-1:0] req_speed_command;
   logic                                  rsp_valid;
   logic                                  rsp_ready;
   logic signed [jspc_pkg::DataWidth-1:0] rsp_measured_speed;
   logic [jspc_pkg::DataWidth-1:0]        rsp_position;
   logic [1:0]                            rsp_mode_echo;
   logic signed [jspc_pkg::DataWidth-1:0] rsp_reported_pwm;
   logic signed [jspc_pkg::DataWidth-1:0] rsp_target_speed;
   logic signed [jspc_pkg::DataWidth-1:0] rsp_drive_output;
   logic                                  csr_write_enable;
   logic [jspc_pkg::CsrIndexWidth-1:0]    csr_index;
   logic [jspc_pkg::DataWidth-1:0]        csr_write_data;

   // controller model state, kept in step with accepted beats
   logic [jspc_pkg::DataWidth-1:0]        ctl_reg [8];
   logic [jspc_pkg::DataWidth-1:0]        last_pos  = '0;
   logic signed [jspc_pkg::DataWidth-1:0] drive_val = '0;
   logic signed [jspc_pkg::DataWidth-1:0] err_sum   = '0;
   logic signed [jspc_pkg::DataWidth-1:0] last_err  = '0;
   logic signed [jspc_pkg::DataWidth-1:0] held_tgt  = '0;

   tick_report_type pending_reports [$];
   bit              steady_flow = 1'b0;
   int              mismatch_count = 0;
   int              reports_checked = 0;
   int              ticks_sent = 0;
   int              pid_ticks = 0;
   int              settings_used = 0;
   int              cycle_count = 0;

   directed_tick_type directed_ticks [22] = '{
      '{16'h0000, jspc_pkg::MODE_OFF,    16'h0000, 1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
      '{16'hFFFF, jspc_pkg::MODE_DIRECT, 16'h7FFF, 1'b1, 16'hFFFF, 16'h0000, 16'h0000, 16'h7FFF},
      '{16'h7FFF, jspc_pkg::MODE_DIRECT, 16'h8000, 1'b1, 16'h8000, 16'h7FFF, 16'h0000, 16'h8000},
      '{16'h0000, jspc_pkg::MODE_HOLD,   16'h1234, 1'b1, 16'h8001, 16'h8000, 16'h0000, 16'h8000},
      '{16'h8000, jspc_pkg::MODE_OFF,    16'h7FFF, 1'b1, 16'h8000, 16'h8000, 16'h0000, 16'h0000},
      '{16'h8000, jspc_pkg::MODE_PID,    16'h7FFF, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0},
      '{16'h8010, jspc_pkg::MODE_PID,    16'h7FFF, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0},
      '{16'h8040, jspc_pkg::MODE_PID,    16'h8000, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0},
      '{16'h8040, jspc_pkg::MODE_PID,    16'hFFFB, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0},
      '{16'h8040, jspc_pkg::MODE_PID,    16'h0000, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0},
      '{16'h8040, jspc_pkg::MODE_PID,    16'h0003, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0},
      '{16'h7F00, jspc_pkg::MODE_PID,    16'd500,  1'b0, 16'h0, 16'h0, 16'h0, 16'h0},
      '{16'h7F00, jspc_pkg::MODE_HOLD,   16'h0000, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0},
      '{16'h7F20, jspc_pkg::MODE_PID,    16'd600,  1'b0, 16'h0, 16'h0, 16'h0, 16'h0},
      '{16'h7F20, jspc_pkg::MODE_DIRECT, 16'hFF9C, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0},
      '{16'h7F20, jspc_pkg::MODE_PID,    16'd1000, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0},
      '{16'h7F20, jspc_pkg::MODE_PID,    16'hFC18, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0},
      '{16'h0000, jspc_pkg::MODE_PID,    16'h0000, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0},
      '{16'hFFF0, jspc_pkg::MODE_PID,    16'h0001, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0},
      '{16'hFFF0, jspc_pkg::MODE_OFF,    16'h0000, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0},
      '{16'hFFF0, jspc_pkg::MODE_PID,    16'hFCF7, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0},
      '{16'hFFF5, jspc_pkg::MODE_PID,    16'hFFFF, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0}
   };

   joint_speed_pid_controller_top dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_encoder_count  (req_encoder_count),
      .req_mode           (req_mode),
      .req_speed_command  (req_speed_command),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_measured_speed (rsp_measured_speed),
      .rsp_position       (rsp_position),
      .rsp_mode_echo      (rsp_mode_echo),
      .rsp_reported_pwm   (rsp_reported_pwm),
      .rsp_target_speed   (rsp_target_speed),
      .rsp_drive_output   (rsp_drive_output),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int sym_clamp(input int v, input int lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
   endfunction

   function automatic tick_report_type advance_controller(
      input logic [jspc_pkg::DataWidth-1:0]        enc,
      input jspc_pkg::mode_type                    md,
      input logic signed [jspc_pkg::DataWidth-1:0] cmd
   );
      tick_report_type                       rep;
      logic signed [jspc_pkg::DataWidth-1:0] speed;
      logic signed [jspc_pkg::DataWidth-1:0] diff;
      logic signed [jspc_pkg::DataWidth-1:0] err;
      logic signed [jspc_pkg::DataWidth-1:0] ramp;
      logic signed [jspc_pkg::DataWidth-1:0] sum;
      logic signed [jspc_pkg::DataWidth-1:0] derr;
      logic signed [jspc_pkg::DataWidth-1:0] drive;
      logic signed [jspc_pkg::DataWidth-1:0] kp;
      logic signed [jspc_pkg::DataWidth-1:0] ki;
      logic signed [jspc_pkg::DataWidth-1:0] kd;
      longint                                weighted;
      int                                    dead;
      speed = enc - last_pos;
      rep.speed      = speed;
      rep.position   = enc;
      rep.mode       = md;
      rep.pwm_before = drive_val;
      last_pos = enc;
      case (md)
         jspc_pkg::MODE_OFF: begin
            drive_val = '0;
            err_sum   = '0;
         end
         jspc_pkg::MODE_DIRECT: begin
            drive_val = cmd;
         end
         jspc_pkg::MODE_PID: begin
            held_tgt = 16'(sym_clamp(cmd, ctl_reg[jspc_pkg::REG_SPEED_CAP]));
            diff = held_tgt - speed;
            err  = 16'(sym_clamp(diff, ctl_reg[jspc_pkg::REG_SLOPE_LIMIT]));
            ramp = speed + err;
            sum  = err_sum + err;
            err_sum = 16'(sym_clamp(sum, ctl_reg[jspc_pkg::REG_INTEGRAL_LIMIT]));
            derr = err - last_err;
            kp = ctl_reg[jspc_pkg::REG_GAIN_P];
            ki = ctl_reg[jspc_pkg::REG_GAIN_I];
            kd = ctl_reg[jspc_pkg::REG_GAIN_D];
            weighted = longint'(kp) * longint'(err) + longint'(ki) * longint'(err_sum)
                     + longint'(kd) * longint'(derr);
            // signed division rounds toward zero, as the controller does
            weighted = weighted / jspc_pkg::PidDivisor;
            drive = 16'(ramp + weighted);
            drive = 16'(sym_clamp(drive, ctl_reg[jspc_pkg::REG_PWM_LIMIT]));
            dead = int'(ctl_reg[jspc_pkg::REG_PWM_DEADBAND]);
            if (int'(drive) < dead && int'(drive) > -dead) begin
               drive = '0;
            end
            drive_val = drive;
            last_err  = err;
         end
         default: begin
         end
      endcase
      rep.target = held_tgt;
      rep.drive  = drive_val;
      return rep;
   endfunction

   function automatic void check_field(input string field,
                                       input logic [jspc_pkg::DataWidth-1:0] want_v,
                                       input logic [jspc_pkg::DataWidth-1:0] got_v);
      if (got_v !== want_v) begin
         mismatch_count++;
         if (mismatch_count <= ShownMismatches) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, field, want_v, got_v);
         end
      end
   endfunction

   // called just after a falling edge, returns just after the falling edge after acceptance
   task automatic send_tick(input logic [jspc_pkg::DataWidth-1:0] enc,
                            input jspc_pkg::mode_type md,
                            input logic signed [jspc_pkg::DataWidth-1:0] cmd,
                            input logic use_typed, input tick_report_type typed_rep);
      tick_report_type predicted;
      while (!steady_flow && $urandom_range(99) < 36) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_encoder_count <= enc;
      req_mode          <= md;
      req_speed_command <= cmd;
      do @(posedge clock); while (!req_ready);
      predicted = advance_controller(enc, md, cmd);
      pending_reports.push_back(use_typed ? typed_rep : predicted);
      ticks_sent++;
      if (md == jspc_pkg::MODE_PID) pid_ticks++;
      @(negedge clock);
   endtask

   task automatic program_registers(input logic [jspc_pkg::DataWidth-1:0] vals [8]);
      for (int i = 0; i < 8; i++) begin
         csr_write_enable <= 1'b1;
         csr_index        <= jspc_pkg::csr_index_type'(i);
         csr_write_data   <= vals[i];
         if (i == jspc_pkg::REG_GAIN_P || i == jspc_pkg::REG_GAIN_I
             || i == jspc_pkg::REG_GAIN_D) begin
            ctl_reg[i] = vals[i];
         end else begin
            ctl_reg[i] = vals[i] & 16'h7FFF;
         end
         @(negedge clock);
      end
      csr_write_enable <= 1'b0;
      settings_used++;
   endtask

   // let every beat in flight come out before touching the registers
   task automatic drain_block();
      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ready <= steady_flow || ($urandom_range(99) >= 36);
      end
   end

   always @(posedge clock) begin : response_check
      tick_report_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_reports.size() == 0) begin
            mismatch_count++;
            $display("%0t: response beat with nothing expected, drive %h", $time,
                     rsp_drive_output);
         end else begin
            want = pending_reports.pop_front();
            reports_checked++;
            check_field("measured_speed", want.speed,      rsp_measured_speed);
            check_field("position",       want.position,   rsp_position);
            check_field("mode_echo",      16'(want.mode),  16'(rsp_mode_echo));
            check_field("reported_pwm",   want.pwm_before, rsp_reported_pwm);
            check_field("target_speed",   want.target,     rsp_target_speed);
            check_field("drive_output",   want.drive,      rsp_drive_output);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("%0t: timed out with %0d responses outstanding", $time,
                  pending_reports.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      logic [jspc_pkg::DataWidth-1:0]        vals [8];
      tick_report_type                       typed_rep;
      directed_tick_type                     row;
      logic [jspc_pkg::DataWidth-1:0]        enc;
      logic [jspc_pkg::DataWidth-1:0]        enc_cursor;
      logic signed [jspc_pkg::DataWidth-1:0] cmd;
      jspc_pkg::mode_type                    md;
      int                                    roll;
      int                                    span;
      int                                    pick;

      reset             = 1'b1;
      req_valid         = 1'b0;
      req_encoder_count = '0;
      req_mode          = jspc_pkg::MODE_OFF;
      req_speed_command = '0;
      csr_write_enable  = 1'b0;
      csr_index         = jspc_pkg::REG_SPEED_CAP;
      csr_write_data    = '0;
      for (int i = 0; i < 8; i++) ctl_reg[i] = '0;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      repeat (2) @(negedge clock);

      // directed beats: moderate gains, with a negative derivative gain
      vals = '{16'd1000, 16'd200, 16'd3000, 16'd64, 16'd8, 16'hFFE0, 16'd2000, 16'd50};
      program_registers(vals);
      foreach (directed_ticks[i]) begin
         row = directed_ticks[i];
         typed_rep = '{row.speed, row.enc, row.mode, row.pwm_before, row.target, row.drive};
         send_tick(row.enc, row.mode, row.cmd, row.typed, typed_rep);
      end
      enc_cursor = 16'hFFF5;

      for (int phase = 0; phase < SettingPhases; phase++) begin
         drain_block();
         for (int r = 0; r < 8; r++) begin
            pick = (r == jspc_pkg::REG_GAIN_P || r == jspc_pkg::REG_GAIN_I
                    || r == jspc_pkg::REG_GAIN_D);
            roll = $urandom_range(99);
            case (phase)
               // limits written with bit 15 set, which the narrower registers drop
               0: vals[r] = pick ? 16'h7FFF : 16'hFFFF;
               1: vals[r] = pick ? 16'h8000 : 16'h7FFF;
               2: vals[r] = 16'h0000;
               default: begin
                  if (pick) begin
                     vals[r] = (roll < 70) ? 16'($urandom_range(512)) - 16'd256
                                           : 16'($urandom);
                  end else if (r == jspc_pkg::REG_PWM_DEADBAND) begin
                     vals[r] = (roll < 85) ? 16'($urandom_range(150)) : 16'($urandom);
                  end else begin
                     vals[r] = (roll < 10) ? 16'h0000 :
                               (roll < 75) ? 16'($urandom_range(3000)) : 16'($urandom);
                  end
               end
            endcase
         end
         program_registers(vals);
         steady_flow = (phase == 4);

         for (int n = 0; n < TicksPerPhase; n++) begin
            roll = $urandom_range(99);
            md = (roll < 8)  ? jspc_pkg::MODE_OFF :
                 (roll < 18) ? jspc_pkg::MODE_DIRECT :
                 (roll < 90) ? jspc_pkg::MODE_PID : jspc_pkg::MODE_HOLD;
            roll = $urandom_range(99);
            // mostly plausible motion so the loop actually tracks
            if (roll < 80) begin
               enc = enc_cursor + 16'($urandom_range(400)) - 16'd200;
            end else if (roll < 92) begin
               enc = enc_cursor + 16'($urandom_range(8000)) - 16'd4000;
            end else begin
               enc = 16'($urandom);
            end
            enc_cursor = enc;
            roll = $urandom_range(99);
            span = int'(ctl_reg[jspc_pkg::REG_SPEED_CAP]) + 200;
            if (roll < 60) begin
               pick = $urandom_range(2 * span);
               cmd = 16'(pick - span);
            end else if (roll < 85) begin
               cmd = 16'($urandom);
            end else begin
               case ($urandom_range(3))
                  0: cmd = 16'h7FFF;
                  1: cmd = 16'h8000;
                  2: cmd = ctl_reg[jspc_pkg::REG_SPEED_CAP];
                  default: cmd = -$signed(ctl_reg[jspc_pkg::REG_SPEED_CAP]);
               endcase
            end
            send_tick(enc, md, cmd, 1'b0, '0);
         end
         steady_flow = 1'b0;
      end

      drain_block();
      $display("covered %0d ticks (%0d in pid mode) across %0d register settings",
               ticks_sent, pid_ticks, settings_used);
      $display("%0d response beats compared field by field", reports_checked);
      if (mismatch_count == 0 && pending_reports.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
